// File: src/pcs_pkg.sv
`timescale 1ns / 1ps
// Package for the port character screen: access phase codes, sequencer
// states and response source select. No dependencies.
`default_nettype none

package pcs_pkg;

   // Access phase counter codes (one per port access in the sequence)
   localparam logic [2:0] PH_ROW    = 3'd0;
   localparam logic [2:0] PH_COL    = 3'd1;
   localparam logic [2:0] PH_MODE   = 3'd2;
   localparam logic [2:0] PH_COLOR  = 3'd3;
   localparam logic [2:0] PH_SYMBOL = 3'd4;

   localparam logic [7:0] SPACE_CHAR = 8'd32;
   localparam logic [5:0] COLOR_MAX  = 6'd63;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } seq_state_type;

   // What the response data is taken from
   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_COLOR,
      SRC_SYMBOL
   } rsp_src_type;

endpackage

`default_nettype wire

// File: src/port_character_screen.sv
`timescale 1ns / 1ps
// Top level of the port character screen: phase sequencer, symbol and color
// memories, response register. Depends on pcs_pkg.
`default_nettype none

// Channel  Dir  Ports                          Contents
// -------  ---  -----------------------------  ---------------------------------
// req      in   req_tvalid/tready/tdata/tuser  tdata = data_byte, tuser = action
// rsp      out  rsp_tvalid/tready/tdata        tdata = read_data
//
// One transaction per cycle is sustained while rsp_tready is high: each request makes exactly one
// response, and a memory read (synchronous port) lands directly in
// the read registers that back rsp_tdata.
// After reset a clearing pass writes every cell; req_tready stays low until it is done.
// A stalled response blocks the next request only while rsp_tready is low.

module port_character_screen
   import pcs_pkg::*;
#(
   parameter int ROWS = 20,
   parameter int COLS = 20
) (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tuser,   // [0] action: 0 = port write, 1 = port read

   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [7:0] read_data
);

   localparam int DEPTH = ROWS * COLS;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   seq_state_type   state_ff, state_in;
   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [2:0]      phase_ff, phase_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic            read_mode_ff, read_mode_in;
   logic [5:0]      color_hold_ff, color_hold_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_src_type     rsp_src_ff, rsp_src_in;

   logic [7:0]      symbol_mem [DEPTH];
   logic [5:0]      color_mem  [DEPTH];
   logic [7:0]      sym_rd_ff;
   logic [5:0]      col_rd_ff;

   // ---------------------------------------------------------------------
   // Handshake and request decode
   // ---------------------------------------------------------------------
   logic            accept;
   logic            is_read;
   logic [7:0]      vbyte;
   logic [AW-1:0]   cell_addr;
   logic [7:0]      sym_clamped;
   logic [5:0]      col_clamped;

   // mem port control
   logic            mem_we;
   logic            mem_re;
   logic [AW-1:0]   wr_addr;
   logic [7:0]      wr_sym;
   logic [5:0]      wr_col;

   assign req_tready = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign is_read    = req_tuser;
   assign vbyte      = req_tdata;

   // row and column are already clamped when latched
   assign cell_addr  = AW'(32'(row_ff) * COLS + 32'(col_ff));

   assign sym_clamped = (vbyte > SPACE_CHAR) ? vbyte : SPACE_CHAR;
   assign col_clamped = (vbyte > 8'(COLOR_MAX)) ? COLOR_MAX : vbyte[5:0];

   // ---------------------------------------------------------------------
   // Sequencer: clearing pass, then normal service
   // ---------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Phase counter and held fields
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      read_mode_in  = read_mode_ff;
      color_hold_in = color_hold_ff;
      if (accept) begin
         phase_in = (phase_ff == PH_SYMBOL) ? PH_ROW : phase_ff + 3'd1;
         if (!is_read) begin
            case (phase_ff)
               PH_ROW: begin
                  row_in = (vbyte > 8'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(vbyte);
               end
               PH_COL: begin
                  col_in = (vbyte > 8'(COLS - 1)) ? CW'(COLS - 1) : CW'(vbyte);
               end
               PH_MODE: begin
                  read_mode_in = (vbyte != 8'd0);
               end
               PH_COLOR: begin
                  color_hold_in = col_clamped;
               end
               default: begin
                  // symbol goes straight to memory below
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Memory port control and response select
   // ---------------------------------------------------------------------
   always_comb begin
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      wr_addr    = cell_addr;
      wr_sym     = sym_clamped;
      wr_col     = color_hold_ff;
      rsp_src_in = rsp_src_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we  = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_sym  = SPACE_CHAR;
         wr_col  = 6'd0;
      end else if (accept) begin
         rsp_src_in = SRC_ZERO;
         if (!is_read) begin
            // a write in the symbol phase commits the cell in write mode
            mem_we = (phase_ff == PH_SYMBOL) && !read_mode_ff;
         end else if (read_mode_ff) begin
            if (phase_ff == PH_COLOR) begin
               mem_re     = 1'b1;
               rsp_src_in = SRC_COLOR;
            end else if (phase_ff == PH_SYMBOL) begin
               mem_re     = 1'b1;
               rsp_src_in = SRC_SYMBOL;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Register update
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         phase_ff      <= PH_ROW;
         row_ff        <= '0;
         col_ff        <= '0;
         read_mode_ff  <= 1'b0;
         color_hold_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_src_ff    <= SRC_ZERO;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         phase_ff      <= phase_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         read_mode_ff  <= read_mode_in;
         color_hold_ff <= color_hold_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_src_ff    <= rsp_src_in;
      end
   end

   // Cell memories: one write port, one registered read port. Read data
   // holds until the next memory read, which doubles as the response hold.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         symbol_mem[wr_addr] <= wr_sym;
         color_mem[wr_addr]  <= wr_col;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         sym_rd_ff <= symbol_mem[cell_addr];
         col_rd_ff <= color_mem[cell_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Response output
   // ---------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      case (rsp_src_ff)
         SRC_COLOR:  rsp_tdata = {2'b00, col_rd_ff};
         SRC_SYMBOL: rsp_tdata = sym_rd_ff;
         default:    rsp_tdata = 8'd0;
      endcase
   end

endmodule

`default_nettype wire
